// ----- rtl/core/slcd_pkg.sv -----
// shared constants, codes, command and status types of the scan line decoder
// no dependencies
`default_nettype none

package slcd_pkg;

  // line store and reading limits
  localparam int LINE_BYTES    = 100;
  localparam int READING_LIMIT = 2048;
  localparam int LEN_W         = $clog2(LINE_BYTES);
  localparam int RCNT_W        = $clog2(READING_LIMIT + 1);

  // field widths
  localparam int KIND_W   = 3;
  localparam int RANGE_W  = 18;
  localparam int IDX_W    = 11;
  localparam int STAMP_W  = 24;
  localparam int WRAP_W   = 16;
  localparam int TIME_W   = WRAP_W + STAMP_W;
  localparam int SIX_W    = 6;
  localparam int ACC_W    = 2 * RANGE_W;
  localparam int CNT_W    = 3;

  // character constants
  localparam logic [7:0] CHAR_BIAS = 8'h30;
  localparam logic [7:0] NEWLINE   = 8'h0A;

  // line shapes
  localparam int TIME_CHARS    = 4;
  localparam int TIME_LINE_LEN = 5;
  localparam logic [CNT_W-1:0] GROUP_RANGE      = 3'd3;
  localparam logic [CNT_W-1:0] GROUP_INTENSITY  = 3'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_READING  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TIME     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHECKSUM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOO_MANY = 3'd5;

  typedef struct packed {
    logic              start;
    logic              store;
    logic              rd_en;
    logic              rd_last;
    logic              ptr_clr;
    logic              ptr_inc;
    logic              cnt_clr;
    logic              cnt_inc;
    logic              acc_shift;
    logic              set_carry;
    logic              mv_wr;
    logic              line_end;
    logic              emit;
    logic [KIND_W-1:0] kind;
  } slcd_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic len_full;
    logic len_is_five;
    logic blank_line;
    logic sum_ok;
    logic time_done;
    logic group_done;
    logic grp_avail;
    logic at_limit;
    logic mv_done;
    logic out_free;
  } slcd_sts_t;

  // character value: (c - 0x30) mod 64
  function automatic logic [SIX_W-1:0] six(input logic [7:0] c);
    six = c[SIX_W-1:0] - CHAR_BIAS[SIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/slcd_if.sv -----
// valid/ready channel interfaces for the input beats and result beats
// depends on slcd_pkg
`default_nettype none

interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       with_intensity;

  modport source (output valid, output op, output data_byte, output with_intensity,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input with_intensity,
                  output ready);
endinterface

interface slcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [slcd_pkg::KIND_W-1:0]  kind;
  logic [slcd_pkg::RANGE_W-1:0] range_mm;
  logic [slcd_pkg::RANGE_W-1:0] intensity;
  logic [slcd_pkg::IDX_W-1:0]   reading_index;
  logic [slcd_pkg::TIME_W-1:0]  time_ms;
  logic                         time_repeated;
  logic                         last;

  modport source (output valid, output kind, output range_mm, output intensity,
                  output reading_index, output time_ms, output time_repeated,
                  output last, input ready);
  modport sink   (input valid, input kind, input range_mm, input intensity,
                  input reading_index, input time_ms, input time_repeated,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/slcd_ctrl.sv -----
// controller state machine: scan phase, line processing sequence, result emission
// depends on slcd_pkg
`default_nettype none

module slcd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_ready,
  input  wire slcd_pkg::slcd_sts_t sts,
  output slcd_pkg::slcd_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TIME  = 4'd1;
  localparam logic [3:0] S_DATA  = 4'd2;
  localparam logic [3:0] S_T_CHK = 4'd3;
  localparam logic [3:0] S_T_RD  = 4'd4;
  localparam logic [3:0] S_T_ACC = 4'd5;
  localparam logic [3:0] S_T_OUT = 4'd6;
  localparam logic [3:0] S_D_CHK = 4'd7;
  localparam logic [3:0] S_D_GRP = 4'd8;
  localparam logic [3:0] S_D_RD  = 4'd9;
  localparam logic [3:0] S_D_ACC = 4'd10;
  localparam logic [3:0] S_D_OUT = 4'd11;
  localparam logic [3:0] S_MV_RD = 4'd12;
  localparam logic [3:0] S_MV_WR = 4'd13;
  localparam logic [3:0] S_D_END = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]                  state_r, state_nxt;
  logic [slcd_pkg::KIND_W-1:0] fin_kind_r, fin_kind_nxt;
  logic                        in_fire;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_TIME) || (state_r == S_DATA);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    fin_kind_nxt = fin_kind_r;
    cmd          = '0;
    case (state_r)
      S_IDLE, S_TIME, S_DATA: begin
        if (in_fire) begin
          if (in_op) begin
            cmd.start = 1'b1;
            state_nxt = S_TIME;
          end else if (state_r != S_IDLE) begin
            if (!sts.is_newline) begin
              if (sts.len_full) begin
                fin_kind_nxt = slcd_pkg::KIND_OVERFLOW;
                state_nxt    = S_FIN;
              end else begin
                cmd.store = 1'b1;
              end
            end else if (state_r == S_TIME) begin
              if (!sts.len_is_five) begin
                fin_kind_nxt = slcd_pkg::KIND_CHECKSUM;
                state_nxt    = S_FIN;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
                state_nxt   = S_T_CHK;
              end
            end else begin
              if (sts.blank_line) begin
                fin_kind_nxt = slcd_pkg::KIND_END;
                state_nxt    = S_FIN;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
                state_nxt   = S_D_CHK;
              end
            end
          end
        end
      end
      S_T_CHK: begin
        if (!sts.sum_ok) begin
          fin_kind_nxt = slcd_pkg::KIND_CHECKSUM;
          state_nxt    = S_FIN;
        end else begin
          cmd.ptr_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_T_RD;
        end
      end
      S_T_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_T_ACC;
      end
      S_T_ACC: begin
        cmd.acc_shift = 1'b1;
        state_nxt     = sts.time_done ? S_T_OUT : S_T_RD;
      end
      S_T_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = slcd_pkg::KIND_TIME;
          state_nxt = S_DATA;
        end
      end
      S_D_CHK: begin
        if (!sts.sum_ok) begin
          fin_kind_nxt = slcd_pkg::KIND_CHECKSUM;
          state_nxt    = S_FIN;
        end else begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_D_GRP;
        end
      end
      S_D_GRP: begin
        if (!sts.grp_avail) begin
          cmd.set_carry = 1'b1;
          cmd.cnt_clr   = 1'b1;
          state_nxt     = S_MV_RD;
        end else if (sts.at_limit) begin
          fin_kind_nxt = slcd_pkg::KIND_TOO_MANY;
          state_nxt    = S_FIN;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_D_RD;
        end
      end
      S_D_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_D_ACC;
      end
      S_D_ACC: begin
        cmd.acc_shift = 1'b1;
        state_nxt     = sts.group_done ? S_D_OUT : S_D_RD;
      end
      S_D_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = slcd_pkg::KIND_READING;
          state_nxt = S_D_GRP;
        end
      end
      S_MV_RD: begin
        if (sts.mv_done) begin
          state_nxt = S_D_END;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_MV_WR;
        end
      end
      S_MV_WR: begin
        cmd.mv_wr   = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_MV_RD;
      end
      S_D_END: begin
        cmd.line_end = 1'b1;
        state_nxt    = S_DATA;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = fin_kind_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fin_kind_r <= slcd_pkg::KIND_END;
    end else begin
      state_r    <= state_nxt;
      fin_kind_r <= fin_kind_nxt;
    end
  end

  // a final result is always an end or error kind
  a_fin_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (fin_kind_r != slcd_pkg::KIND_READING &&
                            fin_kind_r != slcd_pkg::KIND_TIME))
    else $error("final result with a reading or timestamp kind");

endmodule

`default_nettype wire

// ----- rtl/core/slcd_dp.sv -----
// datapath: line memory, sums, counters, group decode, time extension, result register
// depends on slcd_pkg
`default_nettype none

module slcd_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [7:0]                         in_data_byte,
  input  wire logic                               in_with_intensity,
  input  wire slcd_pkg::slcd_cmd_t                cmd,
  output slcd_pkg::slcd_sts_t                     sts,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [slcd_pkg::KIND_W-1:0]             out_kind,
  output logic [slcd_pkg::RANGE_W-1:0]            out_range_mm,
  output logic [slcd_pkg::RANGE_W-1:0]            out_intensity,
  output logic [slcd_pkg::IDX_W-1:0]              out_reading_index,
  output logic [slcd_pkg::TIME_W-1:0]             out_time_ms,
  output logic                                    out_time_repeated,
  output logic                                    out_last
);

  localparam int LW = slcd_pkg::LEN_W;

  logic [7:0]                    line_mem [slcd_pkg::LINE_BYTES];
  logic [7:0]                    rd_data_r;
  logic [LW-1:0]                 rd_addr, wr_addr;
  logic [7:0]                    wr_data;
  logic                          wr_en;

  logic                          intensity_mode_r;
  logic [LW-1:0]                 line_length_r;
  logic [slcd_pkg::CNT_W-1:0]    carry_count_r;
  logic [7:0]                    running_sum_r;
  logic [7:0]                    sum_before_last_r;
  logic [slcd_pkg::STAMP_W-1:0]  previous_time_r;
  logic [slcd_pkg::WRAP_W-1:0]   wrap_count_r;
  logic [slcd_pkg::RCNT_W-1:0]   reading_count_r;
  logic [LW-1:0]                 ptr_r;
  logic [slcd_pkg::CNT_W-1:0]    cnt_r;
  logic [slcd_pkg::ACC_W-1:0]    acc_r;
  logic                          out_valid_r;

  logic [slcd_pkg::CNT_W-1:0]    grp_size;
  logic [LW:0]                   total_w;
  logic [LW:0]                   grp_end;
  logic [7:0]                    want;
  logic [slcd_pkg::STAMP_W-1:0]  time_now;
  logic                          time_rep;
  logic [slcd_pkg::WRAP_W-1:0]   wrap_nxt;

  assign grp_size = intensity_mode_r ? slcd_pkg::GROUP_INTENSITY : slcd_pkg::GROUP_RANGE;
  assign total_w  = {1'b0, line_length_r} - (LW+1)'(1);
  assign grp_end  = {1'b0, ptr_r} + (LW+1)'(grp_size);
  assign want     = {2'b00, sum_before_last_r[5:0]} + slcd_pkg::CHAR_BIAS;
  assign time_now = acc_r[slcd_pkg::STAMP_W-1:0];
  assign time_rep = (time_now == previous_time_r);
  assign wrap_nxt = (!time_rep && (time_now < previous_time_r)) ?
                    wrap_count_r + slcd_pkg::WRAP_W'(1) : wrap_count_r;

  always_comb begin
    sts.is_newline  = (in_data_byte == slcd_pkg::NEWLINE);
    sts.len_full    = (line_length_r >= LW'(slcd_pkg::LINE_BYTES - 2));
    sts.len_is_five = (line_length_r == LW'(slcd_pkg::TIME_LINE_LEN));
    sts.blank_line  = (line_length_r == LW'(carry_count_r));
    sts.sum_ok      = (rd_data_r == want);
    sts.time_done   = (cnt_r == slcd_pkg::CNT_W'(slcd_pkg::TIME_CHARS));
    sts.group_done  = (cnt_r == grp_size);
    sts.grp_avail   = (grp_end <= total_w);
    sts.at_limit    = (reading_count_r >= slcd_pkg::RCNT_W'(slcd_pkg::READING_LIMIT));
    sts.mv_done     = (cnt_r == carry_count_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // line memory: one write port, one registered read port
  assign rd_addr = cmd.rd_last ? line_length_r - LW'(1) : ptr_r;
  assign wr_en   = cmd.store || cmd.mv_wr;
  assign wr_addr = cmd.store ? line_length_r : LW'(cnt_r);
  assign wr_data = cmd.store ? in_data_byte : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // character accumulator
  always_ff @(posedge clk) begin
    if (cmd.acc_shift) begin
      acc_r <= {acc_r[slcd_pkg::ACC_W-slcd_pkg::SIX_W-1:0], slcd_pkg::six(rd_data_r)};
    end
  end

  // line and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_mode_r  <= 1'b0;
      line_length_r     <= '0;
      carry_count_r     <= '0;
      running_sum_r     <= '0;
      sum_before_last_r <= '0;
      previous_time_r   <= '0;
      wrap_count_r      <= '0;
      reading_count_r   <= '0;
      ptr_r             <= '0;
      cnt_r             <= '0;
    end else begin
      if (cmd.start) begin
        intensity_mode_r  <= in_with_intensity;
        line_length_r     <= '0;
        carry_count_r     <= '0;
        reading_count_r   <= '0;
        running_sum_r     <= '0;
        sum_before_last_r <= '0;
      end
      if (cmd.store) begin
        line_length_r     <= line_length_r + LW'(1);
        sum_before_last_r <= running_sum_r;
        running_sum_r     <= running_sum_r + in_data_byte;
      end
      if (cmd.emit && (cmd.kind == slcd_pkg::KIND_TIME)) begin
        previous_time_r   <= time_now;
        wrap_count_r      <= wrap_nxt;
        line_length_r     <= '0;
        carry_count_r     <= '0;
        running_sum_r     <= '0;
        sum_before_last_r <= '0;
      end
      if (cmd.emit && (cmd.kind == slcd_pkg::KIND_READING)) begin
        reading_count_r <= reading_count_r + slcd_pkg::RCNT_W'(1);
      end
      if (cmd.set_carry) begin
        carry_count_r <= slcd_pkg::CNT_W'(total_w - {1'b0, ptr_r});
      end
      if (cmd.line_end) begin
        line_length_r     <= LW'(carry_count_r);
        running_sum_r     <= '0;
        sum_before_last_r <= '0;
      end
      if (cmd.ptr_clr) begin
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + LW'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + slcd_pkg::CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      case (cmd.kind)
        slcd_pkg::KIND_READING: begin
          if (intensity_mode_r) begin
            out_range_mm  <= acc_r[slcd_pkg::ACC_W-1:slcd_pkg::RANGE_W];
            out_intensity <= acc_r[slcd_pkg::RANGE_W-1:0];
          end else begin
            out_range_mm  <= acc_r[slcd_pkg::RANGE_W-1:0];
            out_intensity <= '0;
          end
          out_reading_index <= reading_count_r[slcd_pkg::IDX_W-1:0];
          out_time_ms       <= '0;
          out_time_repeated <= 1'b0;
          out_last          <= !sts.grp_avail;
        end
        slcd_pkg::KIND_TIME: begin
          out_range_mm      <= '0;
          out_intensity     <= '0;
          out_reading_index <= '0;
          out_time_ms       <= {wrap_nxt, time_now};
          out_time_repeated <= time_rep;
          out_last          <= 1'b1;
        end
        default: begin
          out_range_mm      <= '0;
          out_intensity     <= '0;
          out_reading_index <= '0;
          out_time_ms       <= '0;
          out_time_repeated <= 1'b0;
          out_last          <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_length_r <= LW'(slcd_pkg::LINE_BYTES - 2))
    else $error("line length beyond the store");

  a_carry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    carry_count_r < grp_size)
    else $error("carried characters fill a whole group");

  a_read_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.kind == slcd_pkg::KIND_READING)) |-> !sts.at_limit)
    else $error("reading emitted past the reading limit");

  a_time_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.kind == slcd_pkg::KIND_TIME)) |=> (line_length_r == '0))
    else $error("line not cleared after timestamp");

endmodule

`default_nettype wire

// ----- rtl/core/scan_line_decoder_core.sv -----
// scan line decoder top level: controller plus datapath on two valid/ready channels
// depends on slcd_pkg, slcd_if, slcd_ctrl, slcd_dp
`default_nettype none

// decodes the byte stream of one range-scan reply. a start beat (op 1) arms the block and
// picks range-only (3-character groups) or range-plus-intensity (6-character groups). the
// first line is a timestamp (four characters, sum, newline) that comes out as kind 1 with
// a 16-bit wrap count above the 24-bit time; every later line is sum-checked and decoded
// into readings (kind 0) with their index, leftover characters carried to the next line.
// a blank line gives kind 2; a bad sum, an over-long line or too many readings give kind
// 3, 4 or 5, and all of these return the block to idle. bytes seen while idle are dropped.
// on a newline the block stops taking beats while it walks the line through its line
// memory, whose read is registered: it checks the sum, decodes the timestamp or each group
// character by character, moves the carried characters to the front of the line, and
// waits while the result side stalls. results sit in an output register, so a beat that
// makes no result is taken even while a result waits.

module scan_line_decoder_core (
  input  wire logic     clk,
  input  wire logic     rst_n,
  slcd_in_if.sink       in_ch,
  slcd_out_if.source    out_ch
);

  slcd_pkg::slcd_cmd_t cmd;   // controller commands into the datapath
  slcd_pkg::slcd_sts_t sts;   // datapath status back to the controller

  // sequencer: scan phase, newline processing and result ordering
  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line memory, checksums, group decode and the result register
  slcd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_ch.data_byte),
    .in_with_intensity (in_ch.with_intensity),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_kind          (out_ch.kind),
    .out_range_mm      (out_ch.range_mm),
    .out_intensity     (out_ch.intensity),
    .out_reading_index (out_ch.reading_index),
    .out_time_ms       (out_ch.time_ms),
    .out_time_repeated (out_ch.time_repeated),
    .out_last          (out_ch.last)
  );

endmodule

`default_nettype wire
